@@ sv/fir101_pkg.sv @@
// ----------------------------------------------------------------------------
// fir101_pkg
// Shared types, sizes and the coefficient ROM for the 101-tap band-pass FIR.
// ----------------------------------------------------------------------------
package fir101_pkg;

    localparam int TAPS           = 101;
    localparam int TAPS_FULL      = 101;
    localparam int HALF_TAPS      = 51;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int COEF_W         = 16;
    localparam int TAP_W          = $clog2(TAPS);
    localparam int HALF_W         = $clog2(HALF_TAPS);
    localparam int PROD_W         = SAMPLE_BITS + COEF_W;
    localparam int ACC_W          = PROD_W + $clog2(TAPS);
    localparam int RND_W          = ACC_W - COEF_FRAC_BITS;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_out;
        logic                          saturated;
    } res_t;

    // Q1.15 coefficients, first half plus center; the rest mirror these.
    localparam logic signed [COEF_W-1:0] COEF_HALF [HALF_TAPS] = '{
        -16'sd10,   -16'sd26,   -16'sd21,   16'sd1,     16'sd9,
        -16'sd13,   -16'sd39,   -16'sd33,   16'sd3,     16'sd18,
        -16'sd21,   -16'sd71,   -16'sd59,   16'sd9,     16'sd37,
        -16'sd34,   -16'sd123,  -16'sd100,  16'sd22,    16'sd71,
        -16'sd51,   -16'sd200,  -16'sd158,  16'sd48,    16'sd129,
        -16'sd70,   -16'sd309,  -16'sd237,  16'sd94,    16'sd225,
        -16'sd89,   -16'sd463,  -16'sd347,  16'sd176,   16'sd386,
        -16'sd106,  -16'sd700,  -16'sd515,  16'sd333,   16'sd691,
        -16'sd119,  -16'sd1146, -16'sd847,  16'sd713,   16'sd1475,
        -16'sd128,  -16'sd2577, -16'sd2160, 16'sd2928,  16'sd9794,
        16'sd12995
    };

    // Coefficient of tap i (tap 0 multiplies the newest sample).
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] tap);
        logic [TAP_W-1:0] k;
        if (int'(tap) < HALF_TAPS)
        begin
            k = tap;
        end
        else
        begin
            k = TAP_W'(TAPS_FULL - 1 - int'(tap));
        end
        return COEF_HALF[k[HALF_W-1:0]];
    endfunction

endpackage

@@ sv/fir_bandpass_101_tap_top.sv @@
// ----------------------------------------------------------------------------
// fir_bandpass_101_tap_top
// 101-tap band-pass FIR for ECG samples, one shared multiplier.
// ----------------------------------------------------------------------------
// A sample command is worked from accept to the result beat like this: the
// delay line sits in one synchronous RAM with a single read port, and the
// taps are read one per cycle and fed to one 16x16 multiplier and a 39-bit
// accumulator. cmd_stall is high for the whole of that work and low
// otherwise; a finished result waits in the output register, so the next
// command is taken while the result beat is still stalled. A clear command
// gives no result beat. The RAM is a circular buffer; one valid flop per
// entry makes a never-written or cleared entry read as zero, so reset and
// clear cost no sweep. The sum is exact, rounded to nearest from Q.15 (ties
// away from zero) and saturated to 16 bits signed.
module fir_bandpass_101_tap_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  fir101_pkg::cmd_t cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output fir101_pkg::res_t res
);
    import fir101_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,    // issue one tap read per cycle
        ST_DRAIN,  // wait for read and multiply stages to empty
        ST_ROUND,  // magnitude plus half, shift out fraction
        ST_EMIT    // saturate into the output register
    } state_t;

    localparam logic [TAP_W-1:0]   LAST_ADDR = TAP_W'(TAPS - 1);
    localparam logic [TAP_W-1:0]   ONE_ADDR  = TAP_W'(1);
    localparam logic [ACC_W-1:0]   HALF_LSB  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [RND_W-1:0]   POS_MAX   = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [RND_W-1:0]   NEG_MAX   = RND_W'(1 << (SAMPLE_BITS - 1));
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    state_t state_reg;

    // delay line storage
    logic signed [SAMPLE_BITS-1:0] mem [TAPS];
    logic [TAPS-1:0]               vld_reg;
    logic [TAP_W-1:0]              wp_reg;

    // read issue
    logic [TAP_W-1:0] rd_addr_reg;
    logic [TAP_W-1:0] tap_reg;

    // stage 1: RAM data
    logic                          p1_v_reg;
    logic [TAP_W-1:0]              p1_tap_reg;
    logic signed [SAMPLE_BITS-1:0] mem_q_reg;
    logic                          vld_q_reg;

    // stage 2: product
    logic                     p2_v_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic                    neg_reg;
    logic [RND_W-1:0]        rnd_reg;

    logic cmd_take;
    logic res_free;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] mag_rnd;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                          sat_flag;
    logic signed [SAMPLE_BITS-1:0] tap_data;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign res_free  = !res_valid || !res_stall;

    // entries never written since reset or clear count as zero
    assign tap_data = vld_q_reg ? mem_q_reg : '0;

    assign mag     = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign mag_rnd = mag + HALF_LSB;

    always_comb
    begin
        sat_flag = 1'b0;
        sat_val  = SAMPLE_BITS'(rnd_reg);
        if (!neg_reg)
        begin
            if (rnd_reg > POS_MAX)
            begin
                sat_flag = 1'b1;
                sat_val  = OUT_MAX;
            end
        end
        else
        begin
            if (rnd_reg > NEG_MAX)
            begin
                sat_flag = 1'b1;
                sat_val  = OUT_MIN;
            end
            else
            begin
                sat_val = SAMPLE_BITS'(-rnd_reg);
            end
        end
    end

    // RAM: written on sample accept, read one tap per cycle afterwards
    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.command == CMD_SAMPLE)
        begin
            mem[wp_reg] <= cmd.sample_in;
        end
        mem_q_reg <= mem[rd_addr_reg];
        prod_reg  <= tap_data * coef_at(p1_tap_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vld_reg     <= '0;
            wp_reg      <= '0;
            rd_addr_reg <= '0;
            tap_reg     <= '0;
            p1_v_reg    <= 1'b0;
            p1_tap_reg  <= '0;
            vld_q_reg   <= 1'b0;
            p2_v_reg    <= 1'b0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            rnd_reg     <= '0;
            res_valid   <= 1'b0;
            res         <= '0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                res_valid <= 1'b0;
            end

            p1_v_reg <= (state_reg == ST_RUN);
            // tap index only follows live reads, so it never leaves the ROM range
            if (state_reg == ST_RUN)
            begin
                p1_tap_reg <= tap_reg;
            end
            vld_q_reg  <= vld_reg[rd_addr_reg];
            p2_v_reg   <= p1_v_reg;
            if (p2_v_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_take)
                    begin
                        if (cmd.command == CMD_CLEAR)
                        begin
                            vld_reg <= '0;
                        end
                        else
                        begin
                            vld_reg[wp_reg] <= 1'b1;
                            rd_addr_reg     <= wp_reg;
                            wp_reg          <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + ONE_ADDR;
                            tap_reg         <= '0;
                            acc_reg         <= '0;
                            state_reg       <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    // walk backward in time from the newest entry
                    rd_addr_reg <= (rd_addr_reg == '0) ? LAST_ADDR : rd_addr_reg - ONE_ADDR;
                    tap_reg     <= tap_reg + ONE_ADDR;
                    if (tap_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!p1_v_reg && !p2_v_reg)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    neg_reg   <= acc_reg[ACC_W-1];
                    rnd_reg   <= mag_rnd[ACC_W-1:COEF_FRAC_BITS];
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (res_free)
                    begin
                        res_valid        <= 1'b1;
                        res.filtered_out <= sat_val;
                        res.saturated    <= sat_flag;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_res_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_EMIT))
        else $error("result beat raised outside emit");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd.command == CMD_CLEAR) |=> (vld_reg == '0))
        else $error("clear left valid entries");

    a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (!p1_v_reg && !p2_v_reg))
        else $error("rounding before accumulation finished");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.saturated) |->
            (res.filtered_out == OUT_MAX || res.filtered_out == OUT_MIN))
        else $error("saturated result not at a range limit");

endmodule
